/* src/gmb_pkg.sv */
package gmb_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxCols    = 64;
  localparam int RowW       = 6;
  localparam int ColW       = 6;
  localparam int NumCells   = MaxRows * MaxCols;
  localparam int CellW      = RowW + ColW;
  localparam int QueueDepth = 4096;
  localparam int QPtrW      = 12;
  localparam int QCntW      = 13;
  localparam int DistW      = 12;
  localparam int SizeW      = 7;
  localparam int CmdW       = 2;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SOLVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [0:0] REG_ROWS = 1'd0;
  localparam logic [0:0] REG_COLS = 1'd1;

  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // cell record: visited flag, path flag, predecessor, distance
  typedef struct packed {
    logic             vis;
    logic             path;
    logic [2:0]       pred;
    logic [DistW-1:0] hops;
  } cell_rec_t;

  localparam int RecW = $bits(cell_rec_t);

  typedef struct packed {
    logic             has_solution;
    logic [ColW-1:0]  exit_col;
    logic [DistW-1:0] path_cost;
    logic             reachable;
    logic [DistW-1:0] distance;
    logic             on_path;
    logic             is_wall;
  } result_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

/* src/gmb_ram.sv */
module gmb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/grid_maze_bfs_path_core.sv */
// load writes the wall bit on accept; query reads in S_QRD and S_QOUT, then shows the result in S_OUT
// solve: a clearing sweep over every cell, a seed pass over each column of row 0,
//   a dequeue plus four read-modify-write probes on the cell memory per reached
//   cell, and a read and a write per path cell
// one item at a time: no new command is accepted until the last result is taken
// rst_n synchronous, active low: grid size 64x64, no solve, cell memory unknown
module grid_maze_bfs_path_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command[1:0], cell_row[7:2], cell_col[13:8], wall[14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // has_solution[0], exit_col[6:1], path_cost[18:7],
                                  // reachable[19], distance[31:20], on_path[32], is_wall[33]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW = gmb_pkg::CellW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QRD   = 4'd1;
  localparam logic [3:0] S_QOUT  = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_SEEDR = 4'd4;
  localparam logic [3:0] S_SEEDW = 4'd5;
  localparam logic [3:0] S_DEQ   = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_PRB   = 4'd8;
  localparam logic [3:0] S_PRBW  = 4'd9;
  localparam logic [3:0] S_PTHR  = 4'd10;
  localparam logic [3:0] S_PTHW  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [gmb_pkg::SizeW-1:0] rows_r, cols_r;
  gmb_pkg::result_t res_r, res_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [gmb_pkg::DistW-1:0] udist_r, udist_nxt;
  logic [gmb_pkg::QPtrW-1:0] head_r, head_nxt;
  logic [gmb_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic ex_v_r, ex_v_nxt;
  logic [gmb_pkg::ColW-1:0] ex_c_r, ex_c_nxt;
  logic [gmb_pkg::DistW-1:0] ex_d_r, ex_d_nxt;
  logic nbok_r, nbok_nxt;
  logic [gmb_pkg::SizeW-1:0] er_r, ec_r; // clamped sizes during solve

  // memories
  logic wm_we; logic [AW-1:0] wm_wa, wm_ra; logic wm_wd, wm_rd;
  logic cm_we; logic [AW-1:0] cm_wa, cm_ra;
  gmb_pkg::cell_rec_t cm_wd, cm_rd;
  logic q_we; logic [gmb_pkg::QPtrW-1:0] q_wa, q_ra; logic [AW-1:0] q_wd, q_rd;

  gmb_ram #(.Width(1), .Depth(gmb_pkg::NumCells)) u_wall (
    .clk, .we(wm_we), .waddr(wm_wa), .wdata(wm_wd), .raddr(wm_ra), .rdata(wm_rd));
  gmb_ram #(.Width(gmb_pkg::RecW), .Depth(gmb_pkg::NumCells)) u_cell (
    .clk, .we(cm_we), .waddr(cm_wa), .wdata(cm_wd), .raddr(cm_ra), .rdata(cm_rd));
  gmb_ram #(.Width(AW), .Depth(gmb_pkg::QueueDepth)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [1:0] in_cmd;
  logic [5:0] in_row, in_col;
  logic in_wall;
  assign in_cmd  = in_tdata[1:0];
  assign in_row  = in_tdata[7:2];
  assign in_col  = in_tdata[13:8];
  assign in_wall = in_tdata[14];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  // first field in the lowest bits
  assign out_tdata  = {6'd0, res_r.is_wall, res_r.on_path, res_r.distance, res_r.reachable,
                       res_r.path_cost, res_r.exit_col, res_r.has_solution};

  logic solved_r, solved_nxt;

  // neighbour coordinates of the current cell for direction dir_r
  logic [5:0] ur, uc;
  logic [6:0] vr, vc;
  logic nb_in;
  assign ur = cur_r[AW-1:gmb_pkg::ColW];
  assign uc = cur_r[gmb_pkg::ColW-1:0];
  always_comb begin
    vr = {1'b0, ur};
    vc = {1'b0, uc};
    nb_in = 1'b1;
    case ({1'b0, dir_r})
      gmb_pkg::DIR_UP: begin nb_in = (ur != 6'd0); vr = {1'b0, ur} - 7'd1; end
      gmb_pkg::DIR_RIGHT: begin vc = {1'b0, uc} + 7'd1; nb_in = (vc < ec_r); end
      gmb_pkg::DIR_DOWN: begin vr = {1'b0, ur} + 7'd1; nb_in = (vr < er_r); end
      default: begin nb_in = (uc != 6'd0); vc = {1'b0, uc} - 7'd1; end
    endcase
  end

  // predecessor of the current path cell
  logic [5:0] pr, pc;
  always_comb begin
    pr = ur; pc = uc;
    case (cm_rd.pred)
      gmb_pkg::DIR_UP:    pr = ur + 6'd1;
      gmb_pkg::DIR_RIGHT: pc = uc - 6'd1;
      gmb_pkg::DIR_DOWN:  pr = ur - 6'd1;
      gmb_pkg::DIR_LEFT:  pc = uc + 6'd1;
      default: ;
    endcase
  end

  logic pred_ok;
  always_comb begin
    case (cm_rd.pred)
      gmb_pkg::DIR_UP:    pred_ok = (ur != 6'd63);
      gmb_pkg::DIR_RIGHT: pred_ok = (uc != 6'd0);
      gmb_pkg::DIR_DOWN:  pred_ok = (ur != 6'd0);
      gmb_pkg::DIR_LEFT:  pred_ok = (uc != 6'd63);
      default:            pred_ok = 1'b0;
    endcase
  end

  logic [gmb_pkg::QPtrW-1:0] tail;
  assign tail = head_r + cnt_r[gmb_pkg::QPtrW-1:0];

  // cell memory epoch: visited/path bits valid only after a clear sweep, which each solve runs
  always_comb begin
    state_nxt = state_r; res_nxt = res_r; cur_nxt = cur_r; nb_nxt = nb_r;
    dir_nxt = dir_r; udist_nxt = udist_r; head_nxt = head_r; cnt_nxt = cnt_r;
    ex_v_nxt = ex_v_r; ex_c_nxt = ex_c_r; ex_d_nxt = ex_d_r; nbok_nxt = nbok_r;
    solved_nxt = solved_r;
    wm_we = 1'b0; wm_wa = {in_row, in_col}; wm_wd = in_wall; wm_ra = cur_r;
    cm_we = 1'b0; cm_wa = cur_r; cm_wd = '0; cm_ra = cur_r;
    q_we = 1'b0; q_wa = tail; q_wd = cur_r; q_ra = head_r;
    case (state_r)
      S_IDLE: begin
        res_nxt = '0;
        if (in_tvalid) begin
          cur_nxt = {in_row, in_col};
          case (in_cmd)
            gmb_pkg::CMD_LOAD: begin wm_we = 1'b1; state_nxt = S_OUT; end
            gmb_pkg::CMD_SOLVE: begin cur_nxt = '0; state_nxt = S_CLR; end
            gmb_pkg::CMD_QUERY: begin
              wm_ra = {in_row, in_col}; cm_ra = {in_row, in_col}; state_nxt = S_QRD;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_QRD: state_nxt = S_QOUT;
      S_QOUT: begin
        res_nxt.is_wall = wm_rd;
        if (solved_r) begin
          res_nxt.reachable = cm_rd.vis;
          res_nxt.distance  = cm_rd.vis ? cm_rd.hops : '0;
          res_nxt.on_path   = cm_rd.path;
        end
        state_nxt = S_OUT;
      end
      S_CLR: begin
        cm_we = 1'b1; cm_wa = cur_r; cm_wd = '0;
        cur_nxt = cur_r + 1'b1;
        if (cur_r == '1) begin
          cur_nxt = '0; head_nxt = '0; cnt_nxt = '0; ex_v_nxt = 1'b0;
          state_nxt = S_SEEDR;
        end
      end
      S_SEEDR: begin wm_ra = cur_r; state_nxt = S_SEEDW; end
      S_SEEDW: begin
        if (!wm_rd) begin
          cm_we = 1'b1; cm_wa = cur_r;
          cm_wd = '{vis: 1'b1, path: 1'b0, pred: gmb_pkg::DIR_NONE, hops: '0};
          q_we = 1'b1; q_wd = cur_r; cnt_nxt = cnt_r + 1'b1;
        end
        if (7'(cur_r[5:0]) + 7'd1 >= ec_r) state_nxt = S_DEQ;
        else begin cur_nxt = cur_r + 1'b1; state_nxt = S_SEEDR; end
      end
      S_DEQ: begin
        if (cnt_r == '0) begin
          if (ex_v_r) begin cur_nxt = {6'(er_r - 7'd1), ex_c_r}; state_nxt = S_PTHR; end
          else state_nxt = S_DONE;
        end else begin
          q_ra = head_r; head_nxt = head_r + 1'b1; cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        // queue data arrives; read the cell record next
        cur_nxt = q_rd; cm_ra = q_rd; dir_nxt = 2'(gmb_pkg::DIR_UP);
        state_nxt = S_PRB;
        nbok_nxt = 1'b0;
      end
      S_PRB: begin
        // first entry: cm_rd holds current cell record
        if (!nbok_r) begin
          udist_nxt = cm_rd.hops;
          if (7'(ur) == er_r - 7'd1 &&
              (!ex_v_r || cm_rd.hops < ex_d_r || (cm_rd.hops == ex_d_r && uc < ex_c_r))) begin
            ex_v_nxt = 1'b1; ex_c_nxt = uc; ex_d_nxt = cm_rd.hops;
          end
        end
        nbok_nxt = nb_in;
        nb_nxt = {vr[5:0], vc[5:0]};
        cm_ra = {vr[5:0], vc[5:0]}; wm_ra = {vr[5:0], vc[5:0]};
        state_nxt = S_PRBW;
      end
      S_PRBW: begin
        if (nbok_r && !wm_rd && !cm_rd.vis && cnt_r < 13'(gmb_pkg::QueueDepth)) begin
          cm_we = 1'b1; cm_wa = nb_r;
          cm_wd = '{vis: 1'b1, path: 1'b0, pred: {1'b0, dir_r},
                    hops: (udist_r == gmb_pkg::DistMax) ? udist_r : udist_r + 1'b1};
          q_we = 1'b1; q_wd = nb_r; cnt_nxt = cnt_r + 1'b1;
        end
        nbok_nxt = 1'b1;
        if ({1'b0, dir_r} == gmb_pkg::DIR_LEFT) state_nxt = S_DEQ;
        else begin dir_nxt = dir_r + 1'b1; cm_ra = nb_r; state_nxt = S_PRB; end
      end
      S_PTHR: begin cm_ra = cur_r; state_nxt = S_PTHW; end
      S_PTHW: begin
        cm_we = 1'b1; cm_wa = cur_r; cm_wd = cm_rd; cm_wd.path = 1'b1;
        if (pred_ok && cm_rd.pred != gmb_pkg::DIR_NONE) begin
          cur_nxt = {pr, pc}; state_nxt = S_PTHR;
        end else state_nxt = S_DONE;
      end
      S_DONE: begin
        solved_nxt = 1'b1;
        res_nxt.has_solution = ex_v_r;
        res_nxt.exit_col  = ex_v_r ? ex_c_r : '0;
        res_nxt.path_cost = ex_v_r ? ex_d_r : '0;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rows_r <= 7'd64; cols_r <= 7'd64;
      solved_r <= 1'b0; ex_v_r <= 1'b0; cnt_r <= '0; head_r <= '0;
    end else begin
      state_r <= state_nxt; solved_r <= solved_nxt; ex_v_r <= ex_v_nxt;
      cnt_r <= cnt_nxt; head_r <= head_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmb_pkg::REG_ROWS) rows_r <= cfg_data;
        else cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt; cur_r <= cur_nxt; nb_r <= nb_nxt; dir_r <= dir_nxt;
    udist_r <= udist_nxt; ex_c_r <= ex_c_nxt; ex_d_r <= ex_d_nxt; nbok_r <= nbok_nxt;
    er_r <= gmb_pkg::clamp_size(rows_r, 7'(gmb_pkg::MaxRows));
    ec_r <= gmb_pkg::clamp_size(cols_r, 7'(gmb_pkg::MaxCols));
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 13'(gmb_pkg::QueueDepth)) else $error("queue count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while busy");

endmodule
